// ===== rtl/hfa_pkg.sv =====
// ----------------------------------------------------------------------------
// hfa_pkg
// Shared types and constants of the hole fit allocator: field widths, codes
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package hfa_pkg;

  localparam int OP_W       = 1;
  localparam int HIDX_W     = 4;
  localparam int AMT_W      = 16;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] HOLE_COUNT_RST = 5'd16;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } hfa_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic out_free;
  } hfa_sts_t;

endpackage

// ===== rtl/hfa_ram.sv =====
// ----------------------------------------------------------------------------
// hfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module hfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hfa_ctrl
// Sequencer of the allocator: takes a word, runs the hole scan for a request
// (a load skips it), then commits the table update and result.
// ----------------------------------------------------------------------------
module hfa_ctrl import hfa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_stall,
  input  hfa_sts_t        sts,
  output hfa_cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = (in_op == OP_LOAD) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.issue_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/hfa_datapath.sv =====
// ----------------------------------------------------------------------------
// hfa_datapath
// Hole table, configuration registers, scan compare unit and result register.
// ----------------------------------------------------------------------------
module hfa_datapath import hfa_pkg::*; #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [OP_W-1:0]       in_op,
  input  logic [HIDX_W-1:0]     in_hole_index,
  input  logic [AMT_W-1:0]      in_amount,
  input  hfa_cmd_t              cmd,
  output hfa_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_granted,
  output logic [HIDX_W-1:0]     out_chosen_hole,
  output logic [AMT_W-1:0]      out_left_in_hole
);

  localparam int IDX_W = $clog2(NUM_HOLES);
  localparam int CNT_W = $clog2(NUM_HOLES + 1);
  localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
  localparam int PW    = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;
  localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

  logic [POLICY_W-1:0]  policy_r;
  logic [COUNT_W-1:0]   count_r;
  logic [OP_W-1:0]      op_r;
  logic [HIDX_W-1:0]    idx_r;
  logic [AMT_W-1:0]     amt_r;
  logic [CNT_W-1:0]     limit_r;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [NUM_HOLES-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r;
  logic [HIDX_W-1:0]    out_hole_r;
  logic [AMT_W-1:0]     out_left_r;

  logic [CNT_W-1:0]     limit_sat;
  logic                 issue;
  logic [SIZE_BITS-1:0] rd_data;
  logic [SIZE_BITS-1:0] s_cur;
  logic [CMP_W-1:0]     amt_ext;
  logic                 fits;
  logic                 take;
  logic                 load_op;
  logic                 load_ok;
  logic [CMP_W-1:0]     load_ext;
  logic [PW-1:0]        idx_ext;
  logic [PW-1:0]        pick_ext;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [CMP_W-1:0]     wr_ext;
  logic                 res_granted;

  assign limit_sat = (32'(count_r) > 32'(NUM_HOLES)) ? CNT_W'(NUM_HOLES) : CNT_W'(count_r);

  assign sts.issue_done = (issue_r == limit_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign issue     = cmd.scan && !sts.issue_done;
  assign issue_nxt = cmd.start ? '0 : (issue ? issue_r + CNT_W'(1) : issue_r);

  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_HOLES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (issue),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign s_cur   = valid_r[cmp_idx_r] ? rd_data : '0;
  assign amt_ext = CMP_W'(amt_r);
  assign fits    = (CMP_W'(s_cur) >= amt_ext);

  always_comb begin
    take = 1'b0;
    if (cmp_vld_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (policy_r)
          POL_BEST:  take = (s_cur < best_r);
          POL_WORST: take = (s_cur > best_r);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  assign found_nxt = cmd.start ? 1'b0 : (found_r || take);
  assign pick_nxt  = take ? cmp_idx_r : pick_r;
  assign best_nxt  = take ? s_cur : best_r;

  assign load_op  = (op_r == OP_LOAD);
  assign load_ok  = (32'(idx_r) < 32'(NUM_HOLES));
  assign load_ext = (amt_ext > SIZE_MAX) ? SIZE_MAX : amt_ext;
  assign idx_ext  = PW'(idx_r);
  assign pick_ext = PW'(pick_r);

  assign res_granted = load_op ? load_ok : found_r;
  assign wr_en       = cmd.commit && res_granted;
  assign wr_addr     = load_op ? idx_ext[IDX_W-1:0] : pick_r;
  assign wr_data     = load_op ? load_ext[SIZE_BITS-1:0]
                               : (best_r - amt_ext[SIZE_BITS-1:0]);
  assign wr_ext      = CMP_W'(wr_data);

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIRST;
      count_r     <= HOLE_COUNT_RST;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      issue_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIT_POLICY: policy_r <= cfg_wdata[POLICY_W-1:0];
          REG_HOLE_COUNT: count_r  <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= issue;
      found_r     <= found_nxt;
      issue_r     <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      idx_r   <= in_hole_index;
      amt_r   <= in_amount;
      limit_r <= limit_sat;
    end
    if (issue) begin
      cmp_idx_r <= issue_r[IDX_W-1:0];
    end
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    if (cmd.commit) begin
      out_granted_r <= res_granted;
      out_hole_r    <= res_granted ? (load_op ? idx_r : pick_ext[HIDX_W-1:0]) : '0;
      out_left_r    <= res_granted ? wr_ext[AMT_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_hole  = out_hole_r;
  assign out_left_in_hole = out_left_r;

endmodule

// ===== rtl/hole_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// hole_fit_allocator
// Free hole table with first, best and worst fit placement of requests.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_op, in_hole_index, in_amount
//   out_     out  out_valid/out_stall out_granted, out_chosen_hole,
//                                     out_left_in_hole
//   cfg_     in   cfg_we              cfg_index, cfg_wdata
//
// A request takes the word, reads the table once per hole for min(hole_count,
// NUM_HOLES) holes through the single read port, compares the last read and
// commits. A load takes the word and commits. One word is in work at a time.
// The result register frees the input side while a result waits on out_stall.
// Reset clears the table through per-hole valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module hole_fit_allocator import hfa_pkg::*; #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [HIDX_W-1:0]     in_hole_index,
  input  logic [AMT_W-1:0]      in_amount,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_granted,
  output logic [HIDX_W-1:0]     out_chosen_hole,
  output logic [AMT_W-1:0]      out_left_in_hole
);

  hfa_cmd_t cmd;
  hfa_sts_t sts;

  hfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfa_datapath #(
    .NUM_HOLES (NUM_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_hole_index    (in_hole_index),
    .in_amount        (in_amount),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_chosen_hole  (out_chosen_hole),
    .out_left_in_hole (out_left_in_hole)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in work");

  a_wait_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_chosen_hole == '0 && out_left_in_hole == '0))
    else $error("waiting request carries a hole or size");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.scan, cmd.commit}))
    else $error("controller issued overlapping commands");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit with result register full");

endmodule
